// File: hw/rtl/bmir_pkg.sv
// shared types and constants of the bmp mirror engine
package bmir_pkg;

    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int BPP_W       = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_FLIP_MODE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_WIDTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_HEIGHT    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 2'd3;

    localparam logic [1:0] FLIP_H = 2'd0;
    localparam logic [1:0] FLIP_V = 2'd1;

    localparam logic [1:0]            RST_FLIP_MODE       = FLIP_H;
    localparam logic [CFG_DATA_W-1:0] RST_PIXEL_WIDTH     = 9'd1;
    localparam logic [CFG_DATA_W-1:0] RST_PIXEL_HEIGHT    = 9'd1;
    localparam logic [BPP_W-1:0]      RST_BYTES_PER_PIXEL = 3'd3;

    localparam logic CMD_STORE = 1'b0;

    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic flip_h;
        logic flip_v;
    } flip_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SRC,
        ST_ADDR,
        ST_DATA
    } back_state_t;

endpackage

// File: hw/rtl/bmir_ram.sv
// generic simple dual port ram with registered read
module bmir_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/bmir_front.sv
// front end: config registers, geometry pipeline and input word queue
module bmir_front #(
    parameter int MAX_WIDTH           = 256,
    parameter int MAX_HEIGHT          = 256,
    parameter int MAX_BYTES_PER_PIXEL = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               command,
    input  logic [7:0]                         data_byte,
    input  logic                               cfg_we,
    input  logic [bmir_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bmir_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               q_valid,
    output bmir_pkg::item_t                    q_item,
    input  logic                               q_pop,
    output bmir_pkg::flip_t                    geo_flip,
    output logic [$clog2(MAX_WIDTH+1)-1:0]     geo_w,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]    geo_h,
    output logic [bmir_pkg::BPP_W-1:0]         geo_bpp,
    output logic [$clog2(((MAX_WIDTH*MAX_BYTES_PER_PIXEL+3)/4)*4+1)-1:0] geo_data_bytes,
    output logic [$clog2(((MAX_WIDTH*MAX_BYTES_PER_PIXEL+3)/4)*4+1)-1:0] geo_row_bytes,
    output logic [$clog2(((MAX_WIDTH*MAX_BYTES_PER_PIXEL+3)/4)*4*MAX_HEIGHT+1)-1:0] geo_total
);

    localparam int WW      = $clog2(MAX_WIDTH+1);
    localparam int HW      = $clog2(MAX_HEIGHT+1);
    localparam int ROW_MAX = ((MAX_WIDTH*MAX_BYTES_PER_PIXEL+3)/4)*4;
    localparam int RW      = $clog2(ROW_MAX+1);
    localparam int LW      = $clog2(ROW_MAX*MAX_HEIGHT+1);
    localparam int CWW     = (WW > bmir_pkg::CFG_DATA_W) ? WW : bmir_pkg::CFG_DATA_W;
    localparam int CHW     = (HW > bmir_pkg::CFG_DATA_W) ? HW : bmir_pkg::CFG_DATA_W;

    logic [1:0]                     flip_mode_reg;
    logic [bmir_pkg::CFG_DATA_W-1:0] pixel_width_reg;
    logic [bmir_pkg::CFG_DATA_W-1:0] pixel_height_reg;
    logic [bmir_pkg::BPP_W-1:0]     bytes_per_pixel_reg;
    logic [1:0]                     settle_reg;
    logic [1:0]                     settle_next;

    bmir_pkg::flip_t                flip_reg;
    bmir_pkg::flip_t                flip_next;
    logic [WW-1:0]                  w_reg;
    logic [WW-1:0]                  w_next;
    logic [HW-1:0]                  h_reg;
    logic [HW-1:0]                  h_next;
    logic [bmir_pkg::BPP_W-1:0]     bpp_reg;
    logic [bmir_pkg::BPP_W-1:0]     bpp_next;
    logic [RW-1:0]                  data_bytes_reg;
    logic [RW-1:0]                  data_bytes_next;
    logic [RW-1:0]                  row_bytes_reg;
    logic [RW-1:0]                  row_bytes_next;
    logic [LW-1:0]                  total_reg;
    logic [LW-1:0]                  total_next;

    bmir_pkg::item_t                fifo_reg [2];
    logic                           wr_ptr_reg;
    logic                           rd_ptr_reg;
    logic [1:0]                     count_reg;
    logic [1:0]                     count_next;
    logic                           push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_mode_reg       <= bmir_pkg::RST_FLIP_MODE;
            pixel_width_reg     <= bmir_pkg::RST_PIXEL_WIDTH;
            pixel_height_reg    <= bmir_pkg::RST_PIXEL_HEIGHT;
            bytes_per_pixel_reg <= bmir_pkg::RST_BYTES_PER_PIXEL;
            settle_reg          <= bmir_pkg::SETTLE_CYCLES;
        end
        else
        begin
            settle_reg <= settle_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    bmir_pkg::REG_FLIP_MODE:       flip_mode_reg       <= cfg_data[1:0];
                    bmir_pkg::REG_PIXEL_WIDTH:     pixel_width_reg     <= cfg_data;
                    bmir_pkg::REG_PIXEL_HEIGHT:    pixel_height_reg    <= cfg_data;
                    bmir_pkg::REG_BYTES_PER_PIXEL:
                        bytes_per_pixel_reg <= cfg_data[bmir_pkg::BPP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (cfg_we)
        begin
            settle_next = bmir_pkg::SETTLE_CYCLES;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_next = settle_reg - 2'd1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    // geometry: clamp, row size, frame size
    always_comb
    begin
        flip_next.flip_h = (flip_mode_reg != bmir_pkg::FLIP_V);
        flip_next.flip_v = (flip_mode_reg != bmir_pkg::FLIP_H);

        if (pixel_width_reg == '0)
        begin
            w_next = WW'(1);
        end
        else if (CWW'(pixel_width_reg) > CWW'(MAX_WIDTH))
        begin
            w_next = WW'(MAX_WIDTH);
        end
        else
        begin
            w_next = WW'(pixel_width_reg);
        end

        if (pixel_height_reg == '0)
        begin
            h_next = HW'(1);
        end
        else if (CHW'(pixel_height_reg) > CHW'(MAX_HEIGHT))
        begin
            h_next = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_next = HW'(pixel_height_reg);
        end

        if (bytes_per_pixel_reg == '0)
        begin
            bpp_next = bmir_pkg::BPP_W'(1);
        end
        else if (bytes_per_pixel_reg > bmir_pkg::BPP_W'(MAX_BYTES_PER_PIXEL))
        begin
            bpp_next = bmir_pkg::BPP_W'(MAX_BYTES_PER_PIXEL);
        end
        else
        begin
            bpp_next = bytes_per_pixel_reg;
        end

        data_bytes_next = RW'(RW'(w_reg) * RW'(bpp_reg));
        row_bytes_next  = RW'(((data_bytes_next + RW'(3)) >> 2) << 2);
        total_next      = LW'(LW'(row_bytes_reg) * LW'(h_reg));
    end

    always_ff @(posedge clk)
    begin
        flip_reg       <= flip_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        bpp_reg        <= bpp_next;
        data_bytes_reg <= data_bytes_next;
        row_bytes_reg  <= row_bytes_next;
        total_reg      <= total_next;
    end

    // two word queue toward the back end
    assign in_ready = (count_reg != 2'd2) && (settle_reg == 2'd0);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg].command   <= command;
            fifo_reg[wr_ptr_reg].data_byte <= data_byte;
        end
    end

    assign geo_flip       = flip_reg;
    assign geo_w          = w_reg;
    assign geo_h          = h_reg;
    assign geo_bpp        = bpp_reg;
    assign geo_data_bytes = data_bytes_reg;
    assign geo_row_bytes  = row_bytes_reg;
    assign geo_total      = total_reg;

endmodule

// File: hw/rtl/bmir_back.sv
// back end: load counter, mirrored address sequencer and output register
module bmir_back #(
    parameter int MAX_WIDTH           = 256,
    parameter int MAX_HEIGHT          = 256,
    parameter int MAX_BYTES_PER_PIXEL = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  bmir_pkg::item_t                    q_item,
    output logic                               q_pop,
    input  bmir_pkg::flip_t                    geo_flip,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     geo_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]    geo_h,
    input  logic [bmir_pkg::BPP_W-1:0]         geo_bpp,
    input  logic [$clog2(((MAX_WIDTH*MAX_BYTES_PER_PIXEL+3)/4)*4+1)-1:0] geo_data_bytes,
    input  logic [$clog2(((MAX_WIDTH*MAX_BYTES_PER_PIXEL+3)/4)*4+1)-1:0] geo_row_bytes,
    input  logic [$clog2(((MAX_WIDTH*MAX_BYTES_PER_PIXEL+3)/4)*4*MAX_HEIGHT+1)-1:0] geo_total,
    output logic                               ram_we,
    output logic [$clog2(((MAX_WIDTH*MAX_BYTES_PER_PIXEL+3)/4)*4*MAX_HEIGHT)-1:0] ram_waddr,
    output logic [7:0]                         ram_wdata,
    output logic                               ram_re,
    output logic [$clog2(((MAX_WIDTH*MAX_BYTES_PER_PIXEL+3)/4)*4*MAX_HEIGHT)-1:0] ram_raddr,
    input  logic [7:0]                         ram_rdata,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         out_byte,
    output logic                               frame_last,
    output logic                               not_ready
);

    localparam int WW      = $clog2(MAX_WIDTH+1);
    localparam int HW      = $clog2(MAX_HEIGHT+1);
    localparam int ROW_MAX = ((MAX_WIDTH*MAX_BYTES_PER_PIXEL+3)/4)*4;
    localparam int RW      = $clog2(ROW_MAX+1);
    localparam int RIW     = $clog2(ROW_MAX);
    localparam int DEPTH   = ROW_MAX*MAX_HEIGHT;
    localparam int AW      = $clog2(DEPTH);
    localparam int LW      = $clog2(DEPTH+1);
    localparam int HIW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PIW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW3     = 2*RIW+1;
    localparam int RECIP3  = (2**(RIW+1))/3 + 1;
    localparam int BW      = bmir_pkg::BPP_W;

    bmir_pkg::back_state_t state_reg;
    bmir_pkg::back_state_t state_next;
    logic [LW-1:0]         load_index_reg;
    logic [LW-1:0]         load_index_next;
    logic                  frame_full_reg;
    logic                  frame_full_next;
    logic [HIW-1:0]        out_row_reg;
    logic [HIW-1:0]        out_row_next;
    logic [RIW-1:0]        out_row_byte_reg;
    logic [RIW-1:0]        out_row_byte_next;
    logic [PIW-1:0]        pix_reg;
    logic [PIW-1:0]        pix_next;
    logic [AW-1:0]         row_base_reg;
    logic [AW-1:0]         row_base_next;
    logic [RIW-1:0]        src_byte_reg;
    logic [RIW-1:0]        src_byte_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [7:0]            out_byte_reg;
    logic [7:0]            out_byte_next;
    logic                  frame_last_reg;
    logic                  frame_last_next;
    logic                  not_ready_reg;
    logic                  not_ready_next;

    logic                  full_eff;
    logic                  out_free;
    logic [LW-1:0]         load_inc;
    logic [PW3-1:0]        prod3;
    logic [RIW-1:0]        quo;
    logic [PIW-1:0]        mpix;
    logic [RIW-1:0]        part;
    logic                  use_h;
    logic [HIW-1:0]        src_row;
    logic [RW-1:0]         byte_inc;

    function automatic logic [RIW-1:0] times_bpp(input logic [RIW-1:0] v,
                                                 input logic [BW-1:0] b);
        logic [RIW-1:0] r;
        case (b)
            3'd2:    r = v << 1;
            3'd3:    r = (v << 1) + v;
            3'd4:    r = v << 2;
            default: r = v;
        endcase
        return r;
    endfunction

    assign full_eff = frame_full_reg || (load_index_reg >= geo_total);
    assign out_free = !out_valid_reg || out_ready;
    assign load_inc = load_index_reg + LW'(1);

    // byte within row divided by bytes per pixel
    assign prod3 = PW3'(out_row_byte_reg) * PW3'(RECIP3);

    always_comb
    begin
        case (geo_bpp)
            3'd2:    quo = out_row_byte_reg >> 1;
            3'd3:    quo = prod3[PW3-1 -: RIW];
            3'd4:    quo = out_row_byte_reg >> 2;
            default: quo = out_row_byte_reg;
        endcase
    end

    assign mpix    = PIW'(geo_w - WW'(1) - WW'(pix_reg));
    assign part    = out_row_byte_reg - times_bpp(RIW'(pix_reg), geo_bpp);
    assign use_h   = geo_flip.flip_h && (RW'(out_row_byte_reg) < geo_data_bytes);
    assign src_row = geo_flip.flip_v ? HIW'(geo_h - HW'(1) - HW'(out_row_reg)) : out_row_reg;
    assign byte_inc = RW'(out_row_byte_reg) + RW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bmir_pkg::ST_IDLE;
            load_index_reg   <= '0;
            frame_full_reg   <= 1'b0;
            out_row_reg      <= '0;
            out_row_byte_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            load_index_reg   <= load_index_next;
            frame_full_reg   <= frame_full_next;
            out_row_reg      <= out_row_next;
            out_row_byte_reg <= out_row_byte_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg        <= pix_next;
        row_base_reg   <= row_base_next;
        src_byte_reg   <= src_byte_next;
        out_byte_reg   <= out_byte_next;
        frame_last_reg <= frame_last_next;
        not_ready_reg  <= not_ready_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        load_index_next   = load_index_reg;
        frame_full_next   = frame_full_reg;
        out_row_next      = out_row_reg;
        out_row_byte_next = out_row_byte_reg;
        pix_next          = pix_reg;
        row_base_next     = row_base_reg;
        src_byte_next     = src_byte_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_byte_next     = out_byte_reg;
        frame_last_next   = frame_last_reg;
        not_ready_next    = not_ready_reg;
        q_pop             = 1'b0;
        ram_we            = 1'b0;
        ram_re            = 1'b0;

        case (state_reg)
            bmir_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.command == bmir_pkg::CMD_STORE)
                    begin
                        q_pop           = 1'b1;
                        frame_full_next = full_eff;
                        if (!full_eff)
                        begin
                            ram_we          = 1'b1;
                            load_index_next = load_inc;
                            frame_full_next = (load_inc >= geo_total);
                        end
                    end
                    else if (!full_eff)
                    begin
                        if (out_free)
                        begin
                            q_pop           = 1'b1;
                            out_valid_next  = 1'b1;
                            out_byte_next   = 8'd0;
                            frame_last_next = 1'b0;
                            not_ready_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        q_pop           = 1'b1;
                        frame_full_next = 1'b1;
                        if (HW'(out_row_reg) >= geo_h)
                        begin
                            out_row_next = '0;
                        end
                        if (RW'(out_row_byte_reg) >= geo_row_bytes)
                        begin
                            out_row_byte_next = '0;
                        end
                        state_next = bmir_pkg::ST_DIV;
                    end
                end
            end

            bmir_pkg::ST_DIV:
            begin
                pix_next   = PIW'(quo);
                state_next = bmir_pkg::ST_SRC;
            end

            bmir_pkg::ST_SRC:
            begin
                src_byte_next = use_h ? times_bpp(RIW'(mpix), geo_bpp) + part
                                      : out_row_byte_reg;
                row_base_next = AW'(AW'(src_row) * AW'(geo_row_bytes));
                state_next    = bmir_pkg::ST_ADDR;
            end

            bmir_pkg::ST_ADDR:
            begin
                ram_re     = 1'b1;
                state_next = bmir_pkg::ST_DATA;
            end

            bmir_pkg::ST_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    not_ready_next = 1'b0;
                    if ((HW'(out_row_reg) == geo_h - HW'(1)) &&
                        (RW'(out_row_byte_reg) == geo_row_bytes - RW'(1)))
                    begin
                        frame_last_next   = 1'b1;
                        out_row_next      = '0;
                        out_row_byte_next = '0;
                        load_index_next   = '0;
                        frame_full_next   = 1'b0;
                    end
                    else
                    begin
                        frame_last_next = 1'b0;
                        if (byte_inc >= geo_row_bytes)
                        begin
                            out_row_byte_next = '0;
                            out_row_next      = out_row_reg + HIW'(1);
                        end
                        else
                        begin
                            out_row_byte_next = RIW'(byte_inc);
                        end
                    end
                    state_next = bmir_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bmir_pkg::ST_IDLE;
            end
        endcase
    end

    assign ram_waddr  = AW'(load_index_reg);
    assign ram_wdata  = q_item.data_byte;
    assign ram_raddr  = row_base_reg + AW'(src_byte_reg);

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign frame_last = frame_last_reg;
    assign not_ready  = not_ready_reg;

    a_store_only_when_filling: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !frame_full_reg)
        else $error("frame store written while frame full");

    a_fetch_only_on_full_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bmir_pkg::ST_IDLE) |-> frame_full_reg)
        else $error("fetch sequence running without a full frame");

    a_read_feeds_data: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (state_reg == bmir_pkg::ST_DATA))
        else $error("memory read not followed by data stage");

    a_not_ready_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && not_ready_reg) |-> (!frame_last_reg && out_byte_reg == 8'd0))
        else $error("not ready word carries data");

endmodule

// File: hw/rtl/bmp_image_mirror_engine.sv
// top level of the bmp mirror engine
// store words: one per cycle while the back end is idle, queued, then written to frame memory
// fetch words on a full frame: one at a time, run by the back end address sequencer
//   (divide, mirror, row multiply, registered memory read); result held in the output register
// fetch before the frame is full: not_ready word registered once it leaves the input queue
// reset clears control state and loads config defaults; no word accepted after reset or a
//   config write until the geometry pipeline settles; frame memory contents are undefined
module bmp_image_mirror_engine #(
    parameter int MAX_WIDTH           = 256,
    parameter int MAX_HEIGHT          = 256,
    parameter int MAX_BYTES_PER_PIXEL = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             command,
    input  logic [7:0]                       data_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_byte,
    output logic                             frame_last,
    output logic                             not_ready,
    input  logic                             cfg_we,
    input  logic [bmir_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bmir_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int WW      = $clog2(MAX_WIDTH+1);
    localparam int HW      = $clog2(MAX_HEIGHT+1);
    localparam int ROW_MAX = ((MAX_WIDTH*MAX_BYTES_PER_PIXEL+3)/4)*4;
    localparam int RW      = $clog2(ROW_MAX+1);
    localparam int DEPTH   = ROW_MAX*MAX_HEIGHT;
    localparam int AW      = $clog2(DEPTH);
    localparam int LW      = $clog2(DEPTH+1);

    logic                       q_valid;
    bmir_pkg::item_t            q_item;
    logic                       q_pop;
    bmir_pkg::flip_t            geo_flip;
    logic [WW-1:0]              geo_w;
    logic [HW-1:0]              geo_h;
    logic [bmir_pkg::BPP_W-1:0] geo_bpp;
    logic [RW-1:0]              geo_data_bytes;
    logic [RW-1:0]              geo_row_bytes;
    logic [LW-1:0]              geo_total;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [7:0]                 ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [7:0]                 ram_rdata;

    bmir_front #(
        .MAX_WIDTH           (MAX_WIDTH),
        .MAX_HEIGHT          (MAX_HEIGHT),
        .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .data_byte      (data_byte),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .geo_flip       (geo_flip),
        .geo_w          (geo_w),
        .geo_h          (geo_h),
        .geo_bpp        (geo_bpp),
        .geo_data_bytes (geo_data_bytes),
        .geo_row_bytes  (geo_row_bytes),
        .geo_total      (geo_total)
    );

    bmir_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bmir_back #(
        .MAX_WIDTH           (MAX_WIDTH),
        .MAX_HEIGHT          (MAX_HEIGHT),
        .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .geo_flip       (geo_flip),
        .geo_w          (geo_w),
        .geo_h          (geo_h),
        .geo_bpp        (geo_bpp),
        .geo_data_bytes (geo_data_bytes),
        .geo_row_bytes  (geo_row_bytes),
        .geo_total      (geo_total),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .frame_last     (frame_last),
        .not_ready      (not_ready)
    );

endmodule
